@@ design/stream_sequence_integrity_checker_top_defines.svh @@
// Assertion macros shared by the stream sequence integrity checker RTL.
`ifndef STREAM_SEQUENCE_INTEGRITY_CHECKER_TOP_DEFINES_SVH
`define STREAM_SEQUENCE_INTEGRITY_CHECKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SSIC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ssic assertion failed");
// Expression must never be true outside reset.
`define SSIC_ASSERT_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ssic forbidden condition seen");
`else
`define SSIC_ASSERT(name, prop)
`define SSIC_ASSERT_NEVER(name, expr)
`endif
`endif

@@ design/ssic_pkg.sv @@
// Shared types, constants and codes of the stream sequence integrity checker.
`timescale 1ns / 1ps
package ssic_pkg;

	localparam int MAX_SOURCES_DEF = 16;

	localparam logic [63:0] ID_MULT  = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SEQ_MULT = 64'hbf58_476d_1ce4_e5b9;

	localparam int              CNT_W            = 5;
	localparam logic [CNT_W-1:0] SOURCE_COUNT_RST = 5'd2;

	localparam int   PADDR_W          = 3;
	localparam int   PDATA_W          = 32;
	localparam logic REG_SOURCE_COUNT = 1'b0;

	localparam logic [1:0] VERDICT_GOOD      = 2'd0;
	localparam logic [1:0] VERDICT_CORRUPTED = 2'd1;
	localparam logic [1:0] VERDICT_ORDER     = 2'd2;

	typedef struct packed {
		logic [63:0] source_id;
		logic [63:0] sequence_number;
		logic [63:0] check_word;
	} ssic_in_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [63:0] received_total;
		logic [63:0] corrupted_total;
		logic [63:0] out_of_order_total;
	} ssic_out_t;

	// First-stage hash terms and id range result
	typedef struct packed {
		logic        in_range;
		logic [63:0] id_term;
		logic [63:0] pp_ll;
		logic [31:0] pp_cross;
	} ssic_mix_t;

	typedef struct packed {
		logic corrupt;
		logic order;
	} ssic_flags_t;

endpackage

@@ design/stream_sequence_integrity_checker_top.sv @@
// Top level of the stream sequence integrity checker: pipeline, handshakes, config port.
`timescale 1ns / 1ps
`include "stream_sequence_integrity_checker_top_defines.svh"
// Takes one item per cycle while item_stall is low and returns one result per item, in order.
// An item passes the input register, the check stage and the result register, which offers its
// result. The first stage checks the source id against source_count and MAX_SOURCES and forms
// the partial products of the check hash while the expected-sequence RAM is read; the second
// stage finishes the hash, compares, writes the source's new expected value unless the item is
// corrupted and updates the totals. A write in the second stage is forwarded to an item of the
// same source right behind it, so back-to-back items from one source run at full rate. The
// table clears at reset through per-entry valid bits, with no clearing pass. The stages stall
// independently, so the front keeps taking items while a result waits, until the empty stages
// have filled. source_count lies at byte address 0 of the APB port.
module stream_sequence_integrity_checker_top #(
	parameter int MAX_SOURCES = ssic_pkg::MAX_SOURCES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  ssic_pkg::ssic_in_t             item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output ssic_pkg::ssic_out_t            result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ssic_pkg::PADDR_W-1:0]   paddr,
	input  logic [ssic_pkg::PDATA_W-1:0]   pwdata,
	output logic [ssic_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import ssic_pkg::*;

	localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	logic [CNT_W-1:0] source_count_q;

	logic        valid_s1;
	ssic_in_t    item_s1;
	ssic_mix_t   mix_s1;
	logic [AW-1:0] idx_s1;

	logic          valid_s2;
	ssic_mix_t     mix_s2;
	logic [AW-1:0] idx_s2;
	logic [63:0]   seq_s2;
	logic [63:0]   chk_s2;

	logic adv_s1;
	logic adv_s2;
	logic adv_out;
	logic load_out;

	logic [63:0] seq_prod;
	logic [63:0] hash;
	logic [63:0] exp_seq;
	ssic_flags_t flags;
	ssic_out_t   res_next;

	logic        tbl_rd_en;
	logic        tbl_wr_en;
	logic [63:0] tbl_wr_val;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_count_q <= SOURCE_COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[PADDR_W-1:2])
				REG_SOURCE_COUNT: source_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[PADDR_W-1:2])
			REG_SOURCE_COUNT: prdata = PDATA_W'(source_count_q);
			default:          prdata = '0;
		endcase
	end

	// Stage flow: each stage moves when its successor is empty or moving
	assign adv_out    = !result_valid || !result_stall;
	assign load_out   = valid_s2 && adv_out;
	assign adv_s2     = !valid_s2 || adv_out;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= item_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				result_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			item_s1 <= item;
		end
		if (adv_s2 && valid_s1) begin
			mix_s2 <= mix_s1;
			idx_s2 <= idx_s1;
			seq_s2 <= item_s1.sequence_number;
			chk_s2 <= item_s1.check_word;
		end
		if (load_out) begin
			result <= res_next;
		end
	end

	ssic_mix #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_mix (
		.item        (item_s1),
		.source_count(source_count_q),
		.idx         (idx_s1),
		.mix         (mix_s1)
	);

	// Check stage
	assign seq_prod = {mix_s2.pp_ll[63:32] + mix_s2.pp_cross, mix_s2.pp_ll[31:0]};
	assign hash     = seq_prod ^ mix_s2.id_term;

	assign flags.corrupt = !mix_s2.in_range || (chk_s2 != hash);
	assign flags.order   = !flags.corrupt && (seq_s2 != exp_seq);

	assign tbl_rd_en  = adv_s2 && valid_s1;
	assign tbl_wr_en  = load_out && !flags.corrupt;
	assign tbl_wr_val = seq_s2 + 64'd1;

	ssic_exp_table #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_exp_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (tbl_rd_en),
		.rd_idx (idx_s1),
		.wr_en  (tbl_wr_en),
		.wr_idx (idx_s2),
		.wr_val (tbl_wr_val),
		.exp_seq(exp_seq)
	);

	ssic_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load_out),
		.flags   (flags),
		.res_next(res_next)
	);

	`SSIC_ASSERT_NEVER(a_s1_overwrite, item_valid && !item_stall && valid_s1 && !adv_s2)
	`SSIC_ASSERT(a_s2_hold, (valid_s2 && !adv_out) |=> (valid_s2 && $stable(seq_s2) && $stable(exp_seq)))
	`SSIC_ASSERT(a_fwd_same_src, (tbl_wr_en && tbl_rd_en && (idx_s2 == idx_s1)) |=> (exp_seq == $past(tbl_wr_val)))

endmodule

@@ design/ssic_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ssic_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ssic_mix.sv @@
// First stage: source id range check and partial products of the check hash.
`timescale 1ns / 1ps
module ssic_mix #(
	parameter int MAX_SOURCES = ssic_pkg::MAX_SOURCES_DEF,
	localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
	input  ssic_pkg::ssic_in_t           item,
	input  logic [ssic_pkg::CNT_W-1:0]   source_count,
	output logic [AW-1:0]                idx,
	output ssic_pkg::ssic_mix_t          mix
);
	import ssic_pkg::*;

	logic [31:0] seq_lo;
	logic [31:0] seq_hi;
	logic [31:0] pp_lh;
	logic [31:0] pp_hl;

	assign seq_lo = item.sequence_number[31:0];
	assign seq_hi = item.sequence_number[63:32];

	// Low 64 bits of seq * SEQ_MULT: full low product plus the low halves of the cross terms
	assign mix.pp_ll    = {32'b0, seq_lo} * {32'b0, SEQ_MULT[31:0]};
	assign pp_lh        = seq_lo * SEQ_MULT[63:32];
	assign pp_hl        = seq_hi * SEQ_MULT[31:0];
	assign mix.pp_cross = pp_lh + pp_hl;

	assign mix.in_range = (item.source_id < 64'(MAX_SOURCES)) &&
		(item.source_id < 64'(source_count));

	// Only in-range ids reach the compare, so the narrow index carries the id term
	assign idx         = item.source_id[AW-1:0];
	assign mix.id_term = ID_MULT * 64'(idx);

endmodule

@@ design/ssic_exp_table.sv @@
// Per-source expected sequence table: RAM, valid bits and write forwarding.
`timescale 1ns / 1ps
module ssic_exp_table #(
	parameter int MAX_SOURCES = ssic_pkg::MAX_SOURCES_DEF,
	localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_idx,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_idx,
	input  logic [63:0]   wr_val,
	output logic [63:0]   exp_seq
);
	logic [MAX_SOURCES-1:0] valid_q;
	logic                   vld_rd_q;
	logic                   fwd_hit_q;
	logic [63:0]            fwd_val_q;
	logic [63:0]            ram_rdata;

	ssic_ram #(
		.WIDTH(64),
		.DEPTH(MAX_SOURCES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(wr_val),
		.re   (rd_en),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			vld_rd_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q  <= valid_q[rd_idx];
				// RAM returns old data when the same entry is written in the read cycle
				fwd_hit_q <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_val_q <= wr_val;
		end
	end

	assign exp_seq = fwd_hit_q ? fwd_val_q : (vld_rd_q ? ram_rdata : 64'd0);

endmodule

@@ design/ssic_tally.sv @@
// Verdict encoding and the wrapping received, corrupted and out-of-order counters.
`timescale 1ns / 1ps
module ssic_tally (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ssic_pkg::ssic_flags_t flags,
	output ssic_pkg::ssic_out_t   res_next
);
	import ssic_pkg::*;

	logic [63:0] rx_q;
	logic [63:0] crp_q;
	logic [63:0] ooo_q;

	always_comb begin
		res_next.received_total     = rx_q + 64'd1;
		res_next.corrupted_total    = crp_q;
		res_next.out_of_order_total = ooo_q;
		res_next.verdict            = VERDICT_GOOD;
		if (flags.corrupt) begin
			res_next.corrupted_total = crp_q + 64'd1;
			res_next.verdict         = VERDICT_CORRUPTED;
		end else if (flags.order) begin
			res_next.out_of_order_total = ooo_q + 64'd1;
			res_next.verdict            = VERDICT_ORDER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q  <= '0;
			crp_q <= '0;
			ooo_q <= '0;
		end else if (load) begin
			rx_q  <= res_next.received_total;
			crp_q <= res_next.corrupted_total;
			ooo_q <= res_next.out_of_order_total;
		end
	end

endmodule

@@ sim/stream_sequence_integrity_checker_top_tb.sv @@
// Self-checking testbench of the stream sequence integrity checker: directed table, then random phases.
`timescale 1ns / 1ps
module stream_sequence_integrity_checker_top_tb;
	import ssic_pkg::*;

	localparam int N_SRC        = MAX_SOURCES_DEF;
	localparam int SRC_IDX_W    = $clog2(N_SRC);
	localparam int REG_UNUSED   = 1;	// first index past the register list
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int GAP_MAX      = 18;
	localparam int PHASE_ITEMS  = 50;
	localparam int N_PHASES     = 8;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		int          reg_index;
		logic [31:0] wdata;
		ssic_in_t    it;
		bit          has_typed;
		ssic_out_t   typed;
	} stim_row_t;

	typedef struct {
		bit        has_typed;
		ssic_out_t typed;
	} item_note_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	ssic_in_t            item         = '0;
	logic                result_stall = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [PDATA_W-1:0]  pwdata       = '0;
	logic                item_stall;
	logic                result_valid;
	ssic_out_t           result;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Mirror of the block state
	logic [CNT_W-1:0] src_count_cfg;
	logic [63:0]      next_seq [N_SRC];
	logic [63:0]      received_cnt;
	logic [63:0]      corrupted_cnt;
	logic [63:0]      out_of_order_cnt;

	// Sequence numbers the stimulus generator will hand out next
	logic [63:0] gen_next [N_SRC];

	ssic_out_t  pending_results [$];
	item_note_t item_notes [$];
	int         errors       = 0;
	int         src_gap_max  = 0;
	int         sink_gap_max = 0;
	int         sink_wait    = 0;
	int         idle_cycles  = 0;

	stream_sequence_integrity_checker_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] tag_hash(logic [63:0] id, logic [63:0] seq);
		logic [63:0] id_term;
		logic [63:0] seq_term;
		id_term  = id * ID_MULT;
		seq_term = seq * SEQ_MULT;
		return id_term ^ seq_term;
	endfunction

	function automatic int sources_live();
		return (src_count_cfg > N_SRC) ? N_SRC : int'(src_count_cfg);
	endfunction

	// Advance the mirror by one item and return the totals it should report
	function automatic ssic_out_t check_item(ssic_in_t it);
		ssic_out_t r;
		int        idx;
		r.verdict    = VERDICT_GOOD;
		received_cnt = received_cnt + 1;
		if (it.source_id >= 64'(sources_live()) ||
				it.check_word != tag_hash(it.source_id, it.sequence_number)) begin
			corrupted_cnt = corrupted_cnt + 1;
			r.verdict     = VERDICT_CORRUPTED;
		end else begin
			idx = int'(it.source_id[SRC_IDX_W-1:0]);
			if (it.sequence_number != next_seq[idx]) begin
				out_of_order_cnt = out_of_order_cnt + 1;
				r.verdict        = VERDICT_ORDER;
			end
			next_seq[idx] = it.sequence_number + 1;
		end
		r.received_total     = received_cnt;
		r.corrupted_total    = corrupted_cnt;
		r.out_of_order_total = out_of_order_cnt;
		return r;
	endfunction

	function automatic stim_row_t item_row(logic [63:0] id, logic [63:0] seq, logic [63:0] flip);
		stim_row_t r;
		r.kind               = ROW_ITEM;
		r.reg_index          = 0;
		r.wdata              = '0;
		r.it.source_id       = id;
		r.it.sequence_number = seq;
		r.it.check_word      = tag_hash(id, seq) ^ flip;
		r.has_typed          = 1'b0;
		r.typed              = '0;
		return r;
	endfunction

	function automatic stim_row_t with_typed(stim_row_t r, logic [1:0] v, logic [63:0] rc,
			logic [63:0] cc, logic [63:0] oc);
		r.has_typed                = 1'b1;
		r.typed.verdict            = v;
		r.typed.received_total     = rc;
		r.typed.corrupted_total    = cc;
		r.typed.out_of_order_total = oc;
		return r;
	endfunction

	function automatic stim_row_t write_row(int index, logic [31:0] data);
		stim_row_t r;
		r           = item_row(0, 0, 0);
		r.kind      = ROW_WRITE;
		r.reg_index = index;
		r.wdata     = data;
		return r;
	endfunction

	// Mostly well-formed items that follow each source, the rest jumps, repeats and damage
	function automatic ssic_in_t random_item();
		ssic_in_t it;
		int       live;
		int       pick;
		int       idx;
		live = sources_live();
		pick = $urandom_range(0, 99);
		it.source_id = (live > 0) ? 64'($urandom_range(0, live - 1)) : 64'd0;
		idx = int'(it.source_id[SRC_IDX_W-1:0]);
		it.sequence_number = gen_next[idx];
		if (pick < 15)
			it.sequence_number = {$urandom(), $urandom()};
		else if (pick < 20)
			it.sequence_number = it.sequence_number - 1;
		it.check_word = tag_hash(it.source_id, it.sequence_number);
		if (pick >= 90) begin
			it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		end else if (pick >= 80) begin
			if ($urandom_range(0, 1))
				it.source_id = 64'($urandom_range(live, 31));
			else
				it.source_id = {$urandom(), $urandom()};
			it.check_word = tag_hash(it.source_id, it.sequence_number);
		end else if (pick >= 70) begin
			it.check_word = it.check_word ^ (64'd1 << $urandom_range(0, 63));
		end else if (live > 0) begin
			gen_next[idx] = it.sequence_number + 1;
		end
		return it;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	task automatic send_item(input ssic_in_t it, input bit has_typed, input ssic_out_t typed);
		int         gap;
		item_note_t note;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note.has_typed = has_typed;
		note.typed     = typed;
		item_notes.insert(item_notes.size(), note);
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// Hold off until every item in flight has come out
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0 || item_notes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register, then read source_count back
	task automatic config_write(input int index, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * index);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (index == int'(REG_SOURCE_COUNT))
			src_count_cfg = data[CNT_W-1:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(4 * int'(REG_SOURCE_COUNT));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		compare_field("source_count readback", 64'(src_count_cfg), 64'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin : item_monitor
		ssic_out_t  pred;
		item_note_t note;
		if (arst_n && item_valid && !item_stall) begin
			pred = check_item(item);
			if (item_notes.size() == 0) begin
				errors++;
				$display("%0t: item accepted that was never sent: %h", $time, item);
				pending_results.insert(pending_results.size(), pred);
			end else begin
				note = item_notes.pop_front();
				pending_results.insert(pending_results.size(),
					note.has_typed ? note.typed : pred);
			end
		end
	end

	always @(posedge clk) begin : result_sink
		ssic_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: expected nothing actual %h",
					$time, result);
			end else begin
				want = pending_results.pop_front();
				compare_field("verdict", 64'(want.verdict), 64'(result.verdict));
				compare_field("received_total", want.received_total, result.received_total);
				compare_field("corrupted_total", want.corrupted_total, result.corrupted_total);
				compare_field("out_of_order_total", want.out_of_order_total,
					result.out_of_order_total);
			end
			sink_wait = $urandom_range(0, sink_gap_max);
			if (sink_wait > 0)
				result_stall <= 1'b1;
		end else if (sink_wait > 0) begin
			sink_wait--;
			if (sink_wait == 0)
				result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : watchdog
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t rows [$];
		stim_row_t r;
		int        phase;
		int        n;
		int        count;

		src_count_cfg    = SOURCE_COUNT_RST;
		received_cnt     = '0;
		corrupted_cnt    = '0;
		out_of_order_cnt = '0;
		for (n = 0; n < N_SRC; n++) begin
			next_seq[n] = '0;
			gen_next[n] = '0;
		end

		// After reset: two sources, table zero
		rows.insert(rows.size(), with_typed(item_row(0, 0, 0), VERDICT_GOOD, 1, 0, 0));
		rows.insert(rows.size(), with_typed(item_row(0, 1, 0), VERDICT_GOOD, 2, 0, 0));
		rows.insert(rows.size(), with_typed(item_row(1, 5, 0), VERDICT_ORDER, 3, 0, 1));
		rows.insert(rows.size(), with_typed(item_row(2, 0, 0), VERDICT_CORRUPTED, 4, 1, 1));
		rows.insert(rows.size(), with_typed(item_row(0, 2, 1), VERDICT_CORRUPTED, 5, 2, 1));
		r = item_row('1, '1, 0);
		r.it.check_word = '1;
		rows.insert(rows.size(), with_typed(r, VERDICT_CORRUPTED, 6, 3, 1));
		// Sequence wraps from all ones to zero
		rows.insert(rows.size(), item_row(0, '1, 0));
		rows.insert(rows.size(), item_row(0, 0, 0));
		rows.insert(rows.size(), item_row(64'h1_0000_0000, 0, 0));
		rows.insert(rows.size(), item_row(1, 6, 0));
		// Full table
		rows.insert(rows.size(), write_row(int'(REG_SOURCE_COUNT), 32'h0000_0010));
		rows.insert(rows.size(), item_row(15, 0, 0));
		rows.insert(rows.size(), item_row(16, 0, 0));
		rows.insert(rows.size(), item_row(15, 0, 0));
		// Count above the table: only ids below the table size are in range
		rows.insert(rows.size(), write_row(int'(REG_SOURCE_COUNT), 32'hFFFF_FFFF));
		rows.insert(rows.size(), item_row(15, 1, 0));
		rows.insert(rows.size(), item_row(16, 0, 0));
		rows.insert(rows.size(), item_row(30, 0, 0));
		// No sources: everything is corrupted
		rows.insert(rows.size(), write_row(int'(REG_SOURCE_COUNT), 32'hFFFF_FFE0));
		rows.insert(rows.size(), item_row(0, 1, 0));
		rows.insert(rows.size(), write_row(int'(REG_SOURCE_COUNT), 32'h0000_0001));
		rows.insert(rows.size(), item_row(1, 7, 0));
		rows.insert(rows.size(), item_row(0, 1, 0));
		// Write past the register list leaves the count alone
		rows.insert(rows.size(), write_row(REG_UNUSED, 32'hFFFF_FFFF));
		rows.insert(rows.size(), item_row(0, 2, 0));
		rows.insert(rows.size(), item_row(1, 7, 0));
		// Source 1 comes back with its old expected value
		rows.insert(rows.size(), write_row(int'(REG_SOURCE_COUNT), 32'h0000_0002));
		rows.insert(rows.size(), item_row(1, 7, 0));

		src_gap_max  = 3;
		sink_gap_max = 3;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_ITEM) begin
				send_item(rows[i].it, rows[i].has_typed, rows[i].typed);
			end else begin
				drain();
				config_write(rows[i].reg_index, rows[i].wdata);
			end
		end

		for (phase = 0; phase < N_PHASES; phase++) begin
			drain();
			case (phase)
				0: count = 16;
				1: count = 1;
				2: count = 31;
				3: count = 5;
				4: count = 0;
				5: count = 2;
				default: count = $urandom_range(1, 16);
			endcase
			config_write(int'(REG_SOURCE_COUNT), ($urandom() & ~32'h1F) | 32'(count));
			if (phase % 2)
				config_write(REG_UNUSED, $urandom());
			gen_next     = next_seq;
			src_gap_max  = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? GAP_MAX :
				$urandom_range(0, GAP_MAX));
			sink_gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, GAP_MAX);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 3 && n == PHASE_ITEMS / 2)
					drain();
				send_item(random_item(), 1'b0, '0);
			end
		end

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
